FILE: design/round_robin_address_table_defines.svh
// assertion macros shared by the address table design
`ifndef ROUND_ROBIN_ADDRESS_TABLE_DEFINES_SVH
`define ROUND_ROBIN_ADDRESS_TABLE_DEFINES_SVH

// check that holds only out of reset
`define RRAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that holds at every edge, reset included
`define RRAT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/rrat_pkg.sv
package rrat_pkg;

  // fixed field widths
  localparam int unsigned AddrWidth = 32;
  localparam int unsigned ModeWidth = 2;

  // default table depth
  localparam int unsigned SlotCountDef = 16;

  // reserved all-ones address, also the "none" result
  localparam logic [AddrWidth-1:0] AddrNone = '1;
  localparam logic [AddrWidth-1:0] AddrZero = '0;

  // persistence modes
  typedef enum logic [ModeWidth-1:0] {
    MODE_SESSION = 2'd0,
    MODE_STATIC  = 2'd1,
    MODE_DYNAMIC = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_e;

  // commands
  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_GET = 1'b1
  } cmd_e;

endpackage

FILE: design/round_robin_address_table.sv
// Add of an ignored address, or get-next while the table is invalid: result in the cycle after start.
// Add: one slot read per cycle over all SlotCount slots, then the write state if the address is new;
//   the result follows the last slot check (already present) or the write (stored).
// Get-next: one slot checked per cycle from the pointer, then one memory read.
// busy_o drops in the cycle the result strobe is high, so the next start is taken right away.
// Reset (async, active low) clears pointer, mode, table flag and slot valid flags; slots then count as empty.
module round_robin_address_table
  #(
  parameter int unsigned SlotCount = rrat_pkg::SlotCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            command_i,
  input  logic [rrat_pkg::AddrWidth-1:0]  address_i,
  input  logic                            force_req_i,
  // result channel
  output logic                            done_o,
  output logic [rrat_pkg::AddrWidth-1:0]  result_address_o,
  output logic                            hit_o,
  output logic                            stored_new_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rrat_pkg::ModeWidth-1:0]  cfg_data_i
);

  import rrat_pkg::*;

  `include "round_robin_address_table_defines.svh"

  localparam int unsigned IdxWidth = $clog2(SlotCount);
  localparam logic [IdxWidth-1:0] LastSlot = IdxWidth'(SlotCount - 1);
  localparam logic [IdxWidth:0]   CntFull  = (IdxWidth + 1)'(SlotCount);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_WRITE = 5'b00100,
    S_SEEK  = 5'b01000,
    S_FETCH = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [IdxWidth-1:0]    slot_q, slot_d;
  logic [IdxWidth:0]      cnt_q, cnt_d;
  logic [IdxWidth-1:0]    ptr_q, ptr_d;
  logic                   tvalid_q, tvalid_d;
  logic [SlotCount-1:0]   valid_q, valid_d;
  logic                   present_q, present_d;
  logic                   chk_q, chk_d;
  logic                   free_found_q, free_found_d;
  logic [IdxWidth-1:0]    free_slot_q, free_slot_d;
  logic [AddrWidth-1:0]   addr_q, addr_d;
  logic                   force_q, force_d;
  mode_e                  mode_q;
  logic                   done_q, done_d;
  logic [AddrWidth-1:0]   res_q, res_d;
  logic                   hit_q, hit_d;
  logic                   stored_q, stored_d;

  logic                   ram_we;
  logic [IdxWidth-1:0]    ram_waddr;
  logic [AddrWidth-1:0]   ram_rdata;
  logic [IdxWidth-1:0]    slot_inc;
  logic                   rd_match;
  logic                   addr_usable;
  logic                   reject;

  // slot memory, read address follows the scan slot
  rrat_ram #(
    .Width(AddrWidth),
    .Depth(SlotCount)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(addr_q),
    .raddr_i(slot_q),
    .rdata_o(ram_rdata)
  );

  // shared compare and wrap logic
  assign slot_inc    = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign rd_match    = chk_q && (ram_rdata == addr_q);
  assign addr_usable = (address_i != AddrZero) && (address_i != AddrNone);
  assign reject      = (mode_q == MODE_DYNAMIC) && !force_q;
  assign ram_waddr   = free_found_q ? free_slot_q : ptr_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    tvalid_d     = tvalid_q;
    valid_d      = valid_q;
    present_d    = present_q;
    chk_d        = 1'b0;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    addr_d       = addr_q;
    force_d      = force_q;
    done_d       = 1'b0;
    res_d        = res_q;
    hit_d        = hit_q;
    stored_d     = stored_q;
    ram_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          slot_d = ptr_q;
          cnt_d  = '0;
          addr_d = address_i;
          force_d = force_req_i;
          unique case (cmd_e'(command_i))
            CMD_ADD: begin
              if (addr_usable) begin
                tvalid_d     = 1'b1;
                present_d    = 1'b0;
                free_found_d = 1'b0;
                state_d      = S_SCAN;
              end else begin
                done_d   = 1'b1;
                res_d    = AddrNone;
                hit_d    = 1'b0;
                stored_d = 1'b0;
              end
            end
            CMD_GET: begin
              if (tvalid_q) begin
                state_d = S_SEEK;
              end else begin
                done_d   = 1'b1;
                res_d    = AddrNone;
                hit_d    = 1'b0;
                stored_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      // presence scan from the pointer, noting the first empty slot
      S_SCAN: begin
        if (rd_match) begin
          present_d = 1'b1;
        end
        if (cnt_q != CntFull) begin
          chk_d = valid_q[slot_q];
          if (!valid_q[slot_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = slot_q;
          end
          slot_d = slot_inc;
          cnt_d  = cnt_q + 1'b1;
        end else if (present_q || rd_match) begin
          done_d   = 1'b1;
          res_d    = AddrNone;
          hit_d    = 1'b1;
          stored_d = 1'b0;
          state_d  = S_IDLE;
        end else begin
          state_d = S_WRITE;
        end
      end

      // store into the free slot, or over the pointer slot
      S_WRITE: begin
        ram_we             = 1'b1;
        valid_d[ram_waddr] = 1'b1;
        done_d             = 1'b1;
        res_d              = AddrNone;
        hit_d              = 1'b0;
        stored_d           = 1'b1;
        state_d            = S_IDLE;
      end

      // look for the next stored slot from the pointer
      S_SEEK: begin
        if (cnt_q == CntFull) begin
          ptr_d    = (ptr_q == LastSlot) ? '0 : ptr_q + 1'b1;
          done_d   = 1'b1;
          res_d    = AddrNone;
          hit_d    = 1'b0;
          stored_d = 1'b0;
          state_d  = S_IDLE;
        end else if (valid_q[slot_q]) begin
          ptr_d   = slot_inc;
          state_d = S_FETCH;
        end else begin
          slot_d = slot_inc;
          cnt_d  = cnt_q + 1'b1;
        end
      end

      // read word of the found slot is back
      S_FETCH: begin
        done_d   = 1'b1;
        res_d    = reject ? AddrNone : ram_rdata;
        hit_d    = !reject;
        stored_d = 1'b0;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      tvalid_q <= 1'b0;
      valid_q  <= '0;
      chk_q    <= 1'b0;
      done_q   <= 1'b0;
      mode_q   <= MODE_SESSION;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      tvalid_q <= tvalid_d;
      valid_q  <= valid_d;
      chk_q    <= chk_d;
      done_q   <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= mode_e'(cfg_data_i);
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    cnt_q        <= cnt_d;
    present_q    <= present_d;
    free_found_q <= free_found_d;
    free_slot_q  <= free_slot_d;
    addr_q       <= addr_d;
    force_q      <= force_d;
    res_q        <= res_d;
    hit_q        <= hit_d;
    stored_q     <= stored_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign done_o           = done_q;
  assign result_address_o = res_q;
  assign hit_o            = hit_q;
  assign stored_new_o     = stored_q;

  // every accepted word either answers at once or keeps the block busy
  `RRAT_ASSERT(a_start_progress, (start_i && !busy_o) |=> (done_o || busy_o), "start lost")
  // a stored word never reports a hit or an address
  `RRAT_ASSERT(a_store_shape, (done_o && stored_new_o) |-> (!hit_o && &result_address_o), "bad store")
  // slots are never emptied once filled
  `RRAT_ASSERT(a_valid_sticky, 1'b1 |=> ((~valid_q & $past(valid_q)) == '0), "slot flag cleared")
  // stored slots imply the table flag
  `RRAT_ASSERT_ALWAYS(a_valid_table, (valid_q != '0) |-> tvalid_q, "slot without table flag")

endmodule

FILE: design/rrat_ram.sv
module rrat_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
